FILE: hw/rtl/ffba_pkg.sv
// Shared types, codes and defaults for the first-fit block allocator.
// Used by the channel interfaces, the top level and the testbench.
// No dependencies.
`default_nettype none

package ffba_pkg;

   // Default table depth and block header size in bytes
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 24;

   // Field widths fixed by the item formats
   localparam int ADDR_W   = 24;
   localparam int SIZE_W   = 20;
   localparam int STATUS_W = 3;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;

   // Reset value of the heap limit register
   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 24'hFF_FFFF;

   // One row of the block table
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] bytes;
      logic              is_free;
   } entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ffba_req_if.sv
// Request channel of the first-fit block allocator: valid/ready plus payload.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_req_if;
   import ffba_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, kind, request_size, block_address, input ready);
   modport sink   (input valid, kind, request_size, block_address, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ffba_rsp_if.sv
// Response channel of the first-fit block allocator: valid/ready plus payload.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_rsp_if;
   import ffba_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   payload_address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, payload_address, status, input ready);
   modport sink   (input valid, payload_address, status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ffba_csr_if.sv
// Control register write channel of the first-fit block allocator.
// Depends on ffba_pkg for the heap limit width.
`default_nettype none

interface ffba_csr_if;
   import ffba_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] heap_limit;

   modport source (output valid, heap_limit, input ready);
   modport sink   (input valid, heap_limit, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffba_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator: block table in RAM, scan sequencer, result register.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if, ffba_csr_if and ffba_ram.
//
// Usage:
//   req carries allocate (kind 0, request_size) and free (kind 1, block_address)
//   beats. rsp returns exactly one beat per request: payload_address and status
//   (reused, appended, no room, freed, unknown address). csr writes heap_limit;
//   it is always ready and should only be written while no request is in flight.
//   Each request scans the block table oldest first, one table row per cycle
//   through the single RAM read port, stopping at the first hit. A zero-size
//   allocate skips the scan and answers no room. req is ready only while the
//   sequencer is idle, from the cycle rsp turns valid, so no new request is
//   taken while a scan is in progress.
//   The result is held in an output register; a new request may be accepted
//   while it waits. If rsp stalls and a further result is finished, the
//   sequencer holds that result and takes no request until the register frees.
//   Reset clears the block count, heap break and pending beats and loads the
//   heap limit with its maximum; table rows need no clearing.
`default_nettype none

module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ffba_req_if.sink   req,
   ffba_rsp_if.source rsp,
   ffba_csr_if.sink   csr
);
   import ffba_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int NW = ADDR_W + 1;
   localparam logic [NW-1:0] HDR = NW'(HEADER_BYTES);
   localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

   // Sequencer state codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]   break_ff, break_in;
   logic [ADDR_W-1:0]   limit_ff, limit_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic [IW-1:0]       pidx_ff, pidx_in;
   logic                kind_ff, kind_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   entry_type     rd_data;

   logic          issue;
   logic          slot_free;
   logic [NW-1:0] sum_a, sum_b, sum;
   logic [NW-1:0] need;
   logic          match;

   // Block table
   ffba_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // Shared adder: header-relative address of the row under test, or of the block to append
   always_comb begin
      sum_a = {1'b0, rd_data.base};
      if (state_ff == S_SCAN && !pend_ff) begin
         sum_a = {1'b0, break_ff};
      end
      sum_b = HDR;
      sum   = sum_a + sum_b;
      need  = sum + {{(NW-SIZE_W){1'b0}}, size_ff};
   end

   // Row compare for the request kind
   always_comb begin
      if (kind_ff == KIND_ALLOC) begin
         match = pend_ff && rd_data.is_free && (rd_data.bytes >= size_ff);
      end else begin
         match = pend_ff && (sum == {1'b0, addr_ff});
      end
   end

   assign issue     = (ptr_ff != count_ff);
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      break_in    = break_ff;
      ptr_in      = ptr_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      kind_in     = kind_ff;
      size_in     = size_ff;
      addr_in     = addr_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = pidx_ff;
      wr_data     = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               kind_in = req.kind;
               size_in = req.request_size;
               addr_in = req.block_address;
               ptr_in  = '0;
               if (req.kind == KIND_ALLOC && req.request_size == '0) begin
                  res_addr_in = '0;
                  res_st_in   = ST_NO_ROOM;
                  state_in    = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (match) begin
               // Hit: write the row back with its new free mark
               wr_en           = 1'b1;
               wr_addr         = pidx_ff;
               wr_data         = rd_data;
               wr_data.is_free = (kind_ff == KIND_FREE);
               if (kind_ff == KIND_ALLOC) begin
                  res_addr_in = sum[ADDR_W-1:0];
                  res_st_in   = ST_REUSED;
               end else begin
                  res_addr_in = '0;
                  res_st_in   = ST_FREED;
               end
               state_in = S_EMIT;
            end else if (issue) begin
               // Advance to the next row
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = ptr_ff[IW-1:0];
               ptr_in  = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               // Table exhausted
               state_in    = S_EMIT;
               res_addr_in = '0;
               if (kind_ff == KIND_FREE) begin
                  res_st_in = ST_UNKNOWN;
               end else if (count_ff == FULL || need > {1'b0, limit_ff}) begin
                  res_st_in = ST_NO_ROOM;
               end else begin
                  wr_en           = 1'b1;
                  wr_addr         = count_ff[IW-1:0];
                  wr_data.base    = break_ff;
                  wr_data.bytes   = size_ff;
                  wr_data.is_free = 1'b0;
                  count_in        = count_ff + CW'(1);
                  break_in        = need[ADDR_W-1:0];
                  res_addr_in     = sum[ADDR_W-1:0];
                  res_st_in       = ST_APPENDED;
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, drop a taken beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_st_in    = rsp_st_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_EMIT && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_st_in    = res_st_ff;
      end
   end

   // Heap limit register
   always_comb begin
      limit_in = limit_ff;
      if (csr.valid) begin
         limit_in = csr.heap_limit;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         break_ff     <= '0;
         limit_ff     <= HEAP_LIMIT_RESET;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         break_ff     <= break_in;
         limit_ff     <= limit_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      kind_ff     <= kind_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.payload_address = rsp_addr_ff;
   assign rsp.status          = rsp_st_ff;
   assign csr.ready           = 1'b1;

endmodule

`default_nettype wire

FILE: tb/sv/first_fit_block_allocator_test.sv
// Self-checking testbench for the first-fit block allocator: directed table, then random
// allocate/free traffic checked beat by beat against a behavioural table model.
// Depends on ffba_pkg, the three channel interfaces and the first_fit_block_allocator RTL.
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
   import ffba_pkg::*;

   localparam int MAX_BLOCKS   = MAX_BLOCKS_DEF;
   localparam int HEADER_BYTES = HEADER_BYTES_DEF;
   localparam logic [ADDR_W-1:0] LIMIT_MAX = 24'hFF_FFFF;
   localparam logic [SIZE_W-1:0] SIZE_MAX  = 20'hF_FFFF;
   localparam int RUN_LIMIT_NS = 3_000_000;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct packed {
      logic [ADDR_W-1:0]   payload_address;
      logic [STATUS_W-1:0] status;
   } grant_type;

   typedef enum logic { STEP_BEAT, STEP_LIMIT } step_kind_type;

   typedef struct {
      step_kind_type     step;
      logic              kind;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] address;
      bit                typed;
      grant_type         grant;
   } plan_row_type;

   logic clock;
   logic reset;

   ffba_req_if req_bus ();
   ffba_rsp_if rsp_bus ();
   ffba_csr_if csr_bus ();

   first_fit_block_allocator #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Shadow copy of the block table, break and limit
   logic [ADDR_W-1:0] table_base  [MAX_BLOCKS];
   logic [SIZE_W-1:0] table_bytes [MAX_BLOCKS];
   bit                table_free  [MAX_BLOCKS];
   int                table_count;
   logic [ADDR_W-1:0] heap_break_now;
   logic [ADDR_W-1:0] heap_limit_now;

   grant_type    awaited_grants [$];
   plan_row_type directed_plan [$];
   int           error_count;
   bit           idle_on;
   bit           offering;
   bit           long_hold_due;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("first_fit_block_allocator verification failed");
      $finish;
   end

   // First-fit search, append and free on the shadow table
   function automatic void predict_grant(input logic k, input logic [SIZE_W-1:0] sz,
                                         input logic [ADDR_W-1:0] ad,
                                         output grant_type g);
      int          i;
      bit          done;
      int unsigned need;
      g.payload_address = '0;
      g.status = ST_UNKNOWN;
      done = 0;
      if (k == KIND_ALLOC) begin
         g.status = ST_NO_ROOM;
         if (sz == '0) done = 1;
         for (i = 0; i < table_count && !done; i++) begin
            if (table_free[i] && table_bytes[i] >= sz) begin
               table_free[i] = 0;
               g.payload_address = ADDR_W'(table_base[i] + HEADER_BYTES);
               g.status = ST_REUSED;
               done = 1;
            end
         end
         if (!done) begin
            need = heap_break_now + HEADER_BYTES + sz;
            if (table_count < MAX_BLOCKS && need <= heap_limit_now) begin
               table_base[table_count]  = heap_break_now;
               table_bytes[table_count] = sz;
               table_free[table_count]  = 0;
               g.payload_address = ADDR_W'(heap_break_now + HEADER_BYTES);
               g.status = ST_APPENDED;
               table_count++;
               heap_break_now = need[ADDR_W-1:0];
            end
         end
      end else begin
         for (i = 0; i < table_count && !done; i++) begin
            if (table_base[i] + HEADER_BYTES == ad) begin
               table_free[i] = 1;
               g.status = ST_FREED;
               done = 1;
            end
         end
      end
   endfunction

   function automatic plan_row_type beat_row(input logic k, input logic [SIZE_W-1:0] sz,
                                             input logic [ADDR_W-1:0] ad, input bit typed,
                                             input logic [ADDR_W-1:0] pa,
                                             input logic [STATUS_W-1:0] st);
      plan_row_type r;
      r.step = STEP_BEAT;
      r.kind = k;
      r.size = sz;
      r.address = ad;
      r.typed = typed;
      r.grant.payload_address = pa;
      r.grant.status = st;
      return r;
   endfunction

   function automatic plan_row_type limit_row(input logic [ADDR_W-1:0] v);
      plan_row_type r;
      r = beat_row(KIND_ALLOC, '0, v, 0, '0, ST_NO_ROOM);
      r.step = STEP_LIMIT;
      return r;
   endfunction

   // Offer one request beat, hold it until accepted, then maybe idle
   task automatic send_beat(input logic k, input logic [SIZE_W-1:0] sz,
                            input logic [ADDR_W-1:0] ad, input bit typed,
                            input grant_type typed_grant);
      grant_type predicted;
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= k;
      req_bus.request_size  <= sz;
      req_bus.block_address <= ad;
      offering = 1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_grant(k, sz, ad, predicted);
      awaited_grants.push_back(typed ? typed_grant : predicted);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         offering = 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Drop the request and wait for every outstanding result
   task automatic drain;
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 0;
      end
      while (awaited_grants.size() != 0) @(posedge clock);
   endtask

   // Heap limit write; only called once the block is idle
   task automatic write_limit(input logic [ADDR_W-1:0] v);
      drain();
      csr_bus.valid      <= 1'b1;
      csr_bus.heap_limit <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      heap_limit_now = v;
   endtask

   // Random traffic: mostly allocs and frees of live blocks, some noise
   task automatic run_random(input int n);
      int                i;
      int                pick;
      int                sel;
      int                idx;
      logic              k;
      logic [SIZE_W-1:0] sz;
      logic [ADDR_W-1:0] ad;
      grant_type         none;
      none = '0;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         sz = SIZE_W'($urandom_range(0, SIZE_MAX));
         ad = ADDR_W'($urandom_range(0, LIMIT_MAX));
         if (pick < 50) begin
            k = KIND_ALLOC;
            sel = $urandom_range(0, 39);
            if (sel == 0) sz = '0;
            else if (sel == 1) sz = SIZE_MAX;
            else if (sel > 2) sz = SIZE_W'($urandom_range(1, $urandom_range(1, 600)));
         end else begin
            k = KIND_FREE;
            if (table_count > 0 && pick < 92) begin
               idx = $urandom_range(0, table_count - 1);
               ad = ADDR_W'(table_base[idx] + HEADER_BYTES);
               if (pick >= 85) ad = $urandom_range(0, 1) ? ad + ADDR_W'(1) : ad - ADDR_W'(1);
            end
         end
         send_beat(k, sz, ad, 0, none);
      end
   endtask

   // Result side: check each beat, stall in random bursts or one long hold
   initial begin : result_side
      int        stall_left;
      grant_type want;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_grants.size() == 0) begin
               $display("%0t: unexpected result beat addr %h status %0d", $time,
                        rsp_bus.payload_address, rsp_bus.status);
               error_count++;
            end else begin
               want = awaited_grants.pop_front();
               if (rsp_bus.payload_address !== want.payload_address) begin
                  $display("%0t: payload_address expected %h actual %h", $time,
                           want.payload_address, rsp_bus.payload_address);
                  error_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_bus.status);
                  error_count++;
               end
            end
         end
         if (long_hold_due) begin
            long_hold_due = 0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      int           r;
      int unsigned  near;
      plan_row_type row;
      error_count   = 0;
      idle_on       = 1;
      offering      = 0;
      long_hold_due = 0;
      table_count   = 0;
      heap_break_now = '0;
      heap_limit_now = HEAP_LIMIT_RESET;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KIND_ALLOC;
      req_bus.request_size  <= '0;
      req_bus.block_address <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.heap_limit    <= '0;

      // Directed rows: typed where the answer is obvious, else predicted
      directed_plan.push_back(beat_row(KIND_ALLOC, 0, 0, 1, 0, ST_NO_ROOM));
      directed_plan.push_back(beat_row(KIND_FREE, 0, 24, 1, 0, ST_UNKNOWN));
      directed_plan.push_back(beat_row(KIND_ALLOC, 100, LIMIT_MAX, 1, 24, ST_APPENDED));
      directed_plan.push_back(beat_row(KIND_ALLOC, 1, 0, 1, 148, ST_APPENDED));
      directed_plan.push_back(beat_row(KIND_ALLOC, SIZE_MAX, 0, 1, 173, ST_APPENDED));
      directed_plan.push_back(beat_row(KIND_FREE, SIZE_MAX, 24, 1, 0, ST_FREED));
      // free of a block already free
      directed_plan.push_back(beat_row(KIND_FREE, 0, 24, 1, 0, ST_FREED));
      directed_plan.push_back(beat_row(KIND_ALLOC, 50, 0, 1, 24, ST_REUSED));
      directed_plan.push_back(beat_row(KIND_FREE, 0, 148, 0, 0, ST_FREED));
      directed_plan.push_back(beat_row(KIND_ALLOC, 200, 0, 0, 0, ST_APPENDED));
      directed_plan.push_back(beat_row(KIND_FREE, 0, 0, 1, 0, ST_UNKNOWN));
      directed_plan.push_back(beat_row(KIND_FREE, 0, LIMIT_MAX, 1, 0, ST_UNKNOWN));
      directed_plan.push_back(beat_row(KIND_ALLOC, 1, 0, 1, 148, ST_REUSED));
      directed_plan.push_back(beat_row(KIND_FREE, 0, 173, 0, 0, ST_FREED));
      directed_plan.push_back(beat_row(KIND_ALLOC, SIZE_MAX, 0, 1, 173, ST_REUSED));
      // limit below the break: appends fail, reuse still works
      directed_plan.push_back(limit_row(0));
      directed_plan.push_back(beat_row(KIND_ALLOC, 1, 0, 1, 0, ST_NO_ROOM));
      directed_plan.push_back(beat_row(KIND_FREE, 0, 24, 0, 0, ST_FREED));
      directed_plan.push_back(beat_row(KIND_ALLOC, 100, 0, 1, 24, ST_REUSED));
      // limit exactly reached by one append, passed by the next
      directed_plan.push_back(limit_row(24'd1049006));
      directed_plan.push_back(beat_row(KIND_ALLOC, 10, 0, 0, 0, ST_APPENDED));
      directed_plan.push_back(beat_row(KIND_ALLOC, 1, 0, 1, 0, ST_NO_ROOM));
      directed_plan.push_back(limit_row(LIMIT_MAX));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (r = 0; r < directed_plan.size(); r++) begin
         row = directed_plan[r];
         if (row.step == STEP_LIMIT) write_limit(row.address);
         else send_beat(row.kind, row.size, row.address, row.typed, row.grant);
      end

      // Random phases with limit changes between them
      run_random(150);
      long_hold_due = 1;
      run_random(100);
      near = heap_break_now + $urandom_range(0, 20000);
      if (near > LIMIT_MAX) near = LIMIT_MAX;
      write_limit(near[ADDR_W-1:0]);
      run_random(100);
      write_limit(0);
      run_random(50);
      write_limit(ADDR_W'($urandom_range(0, LIMIT_MAX)));
      run_random(100);
      write_limit(LIMIT_MAX);
      // last stretch without any idling
      drain();
      idle_on = 0;
      run_random(100);
      drain();

      repeat (MAX_BLOCKS + 8) @(posedge clock);
      if (error_count == 0 && awaited_grants.size() == 0) begin
         $display("first_fit_block_allocator verification clean");
      end else begin
         $display("first_fit_block_allocator verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_req_if.sv
hw/rtl/ffba_rsp_if.sv
hw/rtl/ffba_csr_if.sv
hw/rtl/ffba_ram.sv
hw/rtl/first_fit_block_allocator.sv
tb/sv/first_fit_block_allocator_test.sv
